// ===== hdl/ccis_pkg.sv =====
package ccis_pkg;

  localparam int TEETH_PER_REV_DEFAULT = 36;

  localparam logic [1:0] MODE_CRANK    = 2'd0;
  localparam logic [1:0] MODE_CAM      = 2'd1;
  localparam logic [1:0] MODE_THROTTLE = 2'd2;

  localparam int          ADDR_W           = 4;
  localparam logic [1:0]  REG_SPARK_WINDOW = 2'd0;
  localparam logic [1:0]  REG_DWELL_OFFSET = 2'd1;
  localparam logic [1:0]  REG_CAM_GAP      = 2'd2;

  localparam logic [7:0]  SPARK_WINDOW_RESET = 8'd60;
  localparam logic [15:0] DWELL_OFFSET_RESET = 16'd2048;
  localparam logic [7:0]  CAM_GAP_RESET      = 8'd20;

  typedef struct packed {
    logic [7:0]  spark_window_degrees;
    logic [15:0] dwell_offset;
    logic [7:0]  cam_gap_teeth;
  } cfg_t;

  typedef struct packed {
    logic [5:0]  tooth;
    logic [2:0]  speed;
    logic [2:0]  load;
    logic [3:0]  plug;
    logic [3:0]  inj;
    logic [7:0]  duty;
    logic        window;
    logic        arm;
    logic [15:0] deg;
    logic [7:0]  ticks;
  } stage_t;

  typedef struct packed {
    logic [5:0]  tooth;
    logic [2:0]  speed;
    logic [2:0]  load;
    logic        arm;
    logic [15:0] spark_compare;
    logic [15:0] dwell_end;
    logic [3:0]  plug;
    logic [3:0]  inj;
    logic [7:0]  duty;
    logic        window;
  } out_t;

endpackage

// ===== hdl/crank_cam_ignition_scheduler.sv =====
// Throughput: one transaction per cycle; the four-stage pipeline (input register,
// decode, multiply, divide-by-ten) advances whenever the output register is empty or taken.
// Reset (rst, synchronous, active high) clears all decoder state and pipeline valids
// and restores the configuration registers to their defaults.
module crank_cam_ignition_scheduler #(
  parameter int TEETH_PER_REV = ccis_pkg::TEETH_PER_REV_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ccis_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [7:0]                  tooth_ticks,
  input  logic [7:0]                  throttle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [5:0]                  tooth_position,
  output logic [2:0]                  speed_zone,
  output logic [2:0]                  load_level,
  output logic                        spark_arm,
  output logic [15:0]                 spark_compare,
  output logic [15:0]                 dwell_end_compare,
  output logic [3:0]                  plug_mask,
  output logic [3:0]                  injector_mask,
  output logic [7:0]                  injector_duty,
  output logic                        spark_window
);

  ccis_pkg::cfg_t   cfg;
  ccis_pkg::stage_t s1;
  ccis_pkg::out_t   res;
  logic             en;
  logic             v0, v1, v2, v3;
  logic [1:0]       mode_q;
  logic [7:0]       ticks_q;
  logic [7:0]       throttle_q;

  assign pready   = 1'b1;
  assign en       = !v3 || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spark_window_degrees <= ccis_pkg::SPARK_WINDOW_RESET;
      cfg.dwell_offset         <= ccis_pkg::DWELL_OFFSET_RESET;
      cfg.cam_gap_teeth        <= ccis_pkg::CAM_GAP_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        ccis_pkg::REG_SPARK_WINDOW: cfg.spark_window_degrees <= pwdata[7:0];
        ccis_pkg::REG_DWELL_OFFSET: cfg.dwell_offset <= pwdata[15:0];
        ccis_pkg::REG_CAM_GAP:      cfg.cam_gap_teeth <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ccis_pkg::REG_SPARK_WINDOW: prdata = {24'd0, cfg.spark_window_degrees};
      ccis_pkg::REG_DWELL_OFFSET: prdata = {16'd0, cfg.dwell_offset};
      ccis_pkg::REG_CAM_GAP:      prdata = {24'd0, cfg.cam_gap_teeth};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_q     <= mode;
      ticks_q    <= tooth_ticks;
      throttle_q <= throttle;
    end
  end

  ccis_decode #(
    .TEETH_PER_REV(TEETH_PER_REV)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v0       (v0),
    .mode     (mode_q),
    .ticks    (ticks_q),
    .throttle (throttle_q),
    .cfg      (cfg),
    .s1       (s1)
  );

  ccis_compare u_compare (
    .clk          (clk),
    .en           (en),
    .s1           (s1),
    .dwell_offset (cfg.dwell_offset),
    .res          (res)
  );

  assign out_valid         = v3;
  assign tooth_position    = res.tooth;
  assign speed_zone        = res.speed;
  assign load_level        = res.load;
  assign spark_arm         = res.arm;
  assign spark_compare     = res.spark_compare;
  assign dwell_end_compare = res.dwell_end;
  assign plug_mask         = res.plug;
  assign injector_mask     = res.inj;
  assign injector_duty     = res.duty;
  assign spark_window      = res.window;

endmodule

// ===== hdl/ccis_decode.sv =====
module ccis_decode #(
  parameter int TEETH_PER_REV = ccis_pkg::TEETH_PER_REV_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                v0,
  input  logic [1:0]          mode,
  input  logic [7:0]          ticks,
  input  logic [7:0]          throttle,
  input  ccis_pkg::cfg_t      cfg,
  output ccis_pkg::stage_t    s1
);

  localparam logic [5:0] ADVANCE_ROM [64] = '{
     6'd0,  6'd8,  6'd5,  6'd3,  6'd2,  6'd1,  6'd1,  6'd0,
    6'd14, 6'd12, 6'd10,  6'd8,  6'd8,  6'd6,  6'd6,  6'd5,
    6'd20, 6'd13, 6'd16, 6'd14, 6'd13, 6'd11, 6'd10,  6'd9,
    6'd26, 6'd19, 6'd21, 6'd19, 6'd18, 6'd16, 6'd15, 6'd14,
    6'd32, 6'd21, 6'd26, 6'd24, 6'd23, 6'd21, 6'd20, 6'd18,
    6'd38, 6'd31, 6'd31, 6'd29, 6'd28, 6'd26, 6'd24, 6'd23,
    6'd43, 6'd34, 6'd37, 6'd35, 6'd33, 6'd31, 6'd29, 6'd27,
    6'd46, 6'd44, 6'd42, 6'd40, 6'd38, 6'd36, 6'd34, 6'd32
  };

  localparam logic [6:0] INJECTOR_ROM [64] = '{
    7'd10, 7'd10, 7'd10, 7'd10, 7'd10, 7'd10, 7'd10, 7'd10,
    7'd20, 7'd20, 7'd20, 7'd20, 7'd20, 7'd20, 7'd20, 7'd20,
    7'd30, 7'd30, 7'd30, 7'd30, 7'd30, 7'd30, 7'd30, 7'd30,
    7'd40, 7'd40, 7'd40, 7'd40, 7'd40, 7'd40, 7'd40, 7'd40,
    7'd50, 7'd50, 7'd50, 7'd50, 7'd50, 7'd50, 7'd50, 7'd50,
    7'd60, 7'd60, 7'd60, 7'd60, 7'd60, 7'd60, 7'd60, 7'd60,
    7'd70, 7'd70, 7'd70, 7'd70, 7'd70, 7'd70, 7'd70, 7'd70,
    7'd80, 7'd80, 7'd80, 7'd80, 7'd80, 7'd80, 7'd80, 7'd80
  };

  function automatic logic [2:0] zone_of_ticks(input logic [7:0] t);
    logic [2:0] z;
    priority if (t > 8'd128) z = 3'd0;
    else if (t > 8'd64) z = 3'd1;
    else if (t > 8'd32) z = 3'd2;
    else if (t > 8'd16) z = 3'd3;
    else if (t > 8'd8) z = 3'd4;
    else if (t > 8'd4) z = 3'd5;
    else if (t > 8'd2) z = 3'd6;
    else z = 3'd7;
    return z;
  endfunction

  logic [5:0]  tooth_count, tooth_count_next;
  logic [7:0]  previous_ticks, previous_ticks_next;
  logic [7:0]  cam_phase, cam_phase_next;
  logic [15:0] teeth_since_cam, teeth_since_cam_next;
  logic [2:0]  rpm_level, rpm_level_next;
  logic [2:0]  throttle_zone, throttle_zone_next;
  logic [3:0]  plug_select, plug_select_next;
  logic [3:0]  injector_select, injector_select_next;
  logic [7:0]  duty_reg, duty_reg_next;
  ccis_pkg::stage_t s1_next;

  logic        gap;
  logic [15:0] div3_prod;
  logic [7:0]  t_eff;
  logic [6:0]  tooth;
  logic        arm;
  logic [5:0]  adv;
  logic [15:0] deg;

  // t/3 as t*171 >> 9, exact for 8-bit t
  assign gap       = {1'b0, ticks} > {previous_ticks, 1'b0};
  assign div3_prod = {8'd0, ticks} * 16'd171;
  assign t_eff     = gap ? div3_prod[15:8] >> 1 : ticks;
  assign adv       = ADVANCE_ROM[{rpm_level, throttle_zone}];
  assign deg       = {8'd0, cfg.spark_window_degrees} - {10'd0, adv};

  always_comb begin
    tooth_count_next     = tooth_count;
    previous_ticks_next  = previous_ticks;
    cam_phase_next       = cam_phase;
    teeth_since_cam_next = teeth_since_cam;
    rpm_level_next       = rpm_level;
    throttle_zone_next   = throttle_zone;
    plug_select_next     = plug_select;
    injector_select_next = injector_select;
    duty_reg_next        = duty_reg;
    arm                  = 1'b0;
    tooth                = {1'b0, tooth_count} + (gap ? 7'd2 : 7'd1);
    unique case (mode)
      ccis_pkg::MODE_CRANK: begin
        teeth_since_cam_next = teeth_since_cam + (gap ? 16'd2 : 16'd1);
        previous_ticks_next  = t_eff;
        priority if (tooth > 7'(TEETH_PER_REV - 1)) begin
          tooth          = 7'd0;
          rpm_level_next = zone_of_ticks(t_eff);
        end else if (tooth == 7'd13 || tooth == 7'd14 || tooth == 7'd16 ||
                     tooth == 7'd17 || tooth == 7'd31 || tooth == 7'd32) begin
          tooth = tooth + 7'd1;
        end else if (tooth == 7'd12 || tooth == 7'd30) begin
          arm = 1'b1;
        end else begin
        end
        tooth_count_next = tooth[5:0];
        priority if (tooth_count_next == 6'd1 && cam_phase == 8'd2) plug_select_next = 4'd1;
        else if (tooth_count_next == 6'd1 && cam_phase == 8'd0) plug_select_next = 4'd2;
        else if (tooth_count_next == 6'd19 && cam_phase == 8'd2) plug_select_next = 4'd4;
        else if (tooth_count_next == 6'd19 && cam_phase == 8'd1) plug_select_next = 4'd8;
        else if (tooth_count_next == 6'd15 && cam_phase == 8'd2) injector_select_next = 4'd1;
        else if (tooth_count_next == 6'd15 && cam_phase == 8'd0) injector_select_next = 4'd2;
        else if (tooth_count_next == 6'd33 && cam_phase == 8'd2) injector_select_next = 4'd4;
        else if (tooth_count_next == 6'd33 && cam_phase == 8'd1) injector_select_next = 4'd8;
        else begin
        end
      end
      ccis_pkg::MODE_CAM: begin
        cam_phase_next = (teeth_since_cam > {8'd0, cfg.cam_gap_teeth}) ? 8'd0
                                                                       : cam_phase + 8'd1;
        teeth_since_cam_next = 16'd0;
      end
      ccis_pkg::MODE_THROTTLE: begin
        throttle_zone_next = throttle[7:5];
        duty_reg_next      = {1'b0, INJECTOR_ROM[{rpm_level, throttle[7:5]}]};
      end
      default: begin
      end
    endcase

    s1_next.tooth  = tooth_count_next;
    s1_next.speed  = rpm_level_next;
    s1_next.load   = throttle_zone_next;
    s1_next.plug   = plug_select_next;
    s1_next.inj    = injector_select_next;
    s1_next.duty   = duty_reg_next;
    s1_next.window = (tooth_count_next > 6'd12 && tooth_count_next < 6'd19) ||
                     tooth_count_next >= 6'd30 || tooth_count_next == 6'd0;
    s1_next.arm    = arm;
    s1_next.deg    = deg;
    s1_next.ticks  = t_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tooth_count     <= '0;
      previous_ticks  <= '0;
      cam_phase       <= '0;
      teeth_since_cam <= '0;
      rpm_level       <= '0;
      throttle_zone   <= '0;
      plug_select     <= '0;
      injector_select <= '0;
      duty_reg        <= '0;
    end else if (en && v0) begin
      tooth_count     <= tooth_count_next;
      previous_ticks  <= previous_ticks_next;
      cam_phase       <= cam_phase_next;
      teeth_since_cam <= teeth_since_cam_next;
      rpm_level       <= rpm_level_next;
      throttle_zone   <= throttle_zone_next;
      plug_select     <= plug_select_next;
      injector_select <= injector_select_next;
      duty_reg        <= duty_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

endmodule

// ===== hdl/ccis_compare.sv =====
module ccis_compare (
  input  logic             clk,
  input  logic             en,
  input  ccis_pkg::stage_t s1,
  input  logic [15:0]      dwell_offset,
  output ccis_pkg::out_t   res
);

  ccis_pkg::stage_t s2;
  logic [23:0]      product;
  logic [47:0]      div10_prod;
  logic [15:0]      comp;
  ccis_pkg::out_t   res_next;

  // p/10 as p*ceil(2^27/10) >> 27, exact for p < 2^26
  assign div10_prod = {24'd0, product} * 48'd13421773;
  assign comp       = s2.arm ? {div10_prod[35:27], 7'd0} : 16'd0;

  always_comb begin
    res_next.tooth         = s2.tooth;
    res_next.speed         = s2.speed;
    res_next.load          = s2.load;
    res_next.arm           = s2.arm;
    res_next.spark_compare = comp;
    res_next.dwell_end     = s2.arm ? comp + dwell_offset : 16'd0;
    res_next.plug          = s2.plug;
    res_next.inj           = s2.inj;
    res_next.duty          = s2.duty;
    res_next.window        = s2.window;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2      <= s1;
      product <= s1.deg * {16'd0, s1.ticks};
      res     <= res_next;
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int TEETH = ccis_pkg::TEETH_PER_REV_DEFAULT;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ccis_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = ccis_pkg::MODE_CRANK;
  logic [7:0] tooth_ticks = '0;
  logic [7:0] throttle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] tooth_position;
  logic [2:0] speed_zone;
  logic [2:0] load_level;
  logic spark_arm;
  logic [15:0] spark_compare;
  logic [15:0] dwell_end_compare;
  logic [3:0] plug_mask;
  logic [3:0] injector_mask;
  logic [7:0] injector_duty;
  logic spark_window;

  always #5 clk = ~clk;

  crank_cam_ignition_scheduler uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .tooth_ticks(tooth_ticks), .throttle(throttle),
    .out_valid(out_valid), .out_ready(out_ready),
    .tooth_position(tooth_position), .speed_zone(speed_zone), .load_level(load_level),
    .spark_arm(spark_arm), .spark_compare(spark_compare),
    .dwell_end_compare(dwell_end_compare), .plug_mask(plug_mask),
    .injector_mask(injector_mask), .injector_duty(injector_duty),
    .spark_window(spark_window)
  );

  // advance in degrees, indexed by {rpm zone, load zone}
  logic [5:0] advance_map [64] = '{
     6'd0,  6'd8,  6'd5,  6'd3,  6'd2,  6'd1,  6'd1,  6'd0,
    6'd14, 6'd12, 6'd10,  6'd8,  6'd8,  6'd6,  6'd6,  6'd5,
    6'd20, 6'd13, 6'd16, 6'd14, 6'd13, 6'd11, 6'd10,  6'd9,
    6'd26, 6'd19, 6'd21, 6'd19, 6'd18, 6'd16, 6'd15, 6'd14,
    6'd32, 6'd21, 6'd26, 6'd24, 6'd23, 6'd21, 6'd20, 6'd18,
    6'd38, 6'd31, 6'd31, 6'd29, 6'd28, 6'd26, 6'd24, 6'd23,
    6'd43, 6'd34, 6'd37, 6'd35, 6'd33, 6'd31, 6'd29, 6'd27,
    6'd46, 6'd44, 6'd42, 6'd40, 6'd38, 6'd36, 6'd34, 6'd32
  };

  logic [7:0] cfg_window_deg = ccis_pkg::SPARK_WINDOW_RESET;
  logic [15:0] cfg_dwell = ccis_pkg::DWELL_OFFSET_RESET;
  logic [7:0] cfg_cam_gap = ccis_pkg::CAM_GAP_RESET;

  logic [5:0] tooth_cnt = '0;
  logic [7:0] last_ticks = '0;
  logic [7:0] cam_ph = '0;
  logic [15:0] teeth_after_cam = '0;
  logic [2:0] speed_lvl = '0;
  logic [2:0] load_lvl = '0;
  logic [3:0] plug_sel = '0;
  logic [3:0] inj_sel = '0;
  logic [7:0] duty_val = '0;

  ccis_pkg::out_t pending_results[$];
  int mismatches = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  function automatic logic [2:0] zone_from_ticks(logic [7:0] t);
    if (t > 128) return 3'd0;
    if (t > 64) return 3'd1;
    if (t > 32) return 3'd2;
    if (t > 16) return 3'd3;
    if (t > 8) return 3'd4;
    if (t > 4) return 3'd5;
    if (t > 2) return 3'd6;
    return 3'd7;
  endfunction

  function automatic ccis_pkg::out_t decode_item(logic [1:0] m, logic [7:0] ticks,
                                                 logic [7:0] thr);
    ccis_pkg::out_t r;
    logic [7:0] t;
    logic [6:0] pos;
    logic [15:0] deg;
    logic [31:0] product;
    r = '0;
    if (m == ccis_pkg::MODE_CRANK) begin
      t = ticks;
      if ({1'b0, t} > {last_ticks, 1'b0}) begin
        pos = tooth_cnt + 7'd2;
        teeth_after_cam = teeth_after_cam + 16'd2;
        t = t / 8'd3;
      end else begin
        pos = tooth_cnt + 7'd1;
        teeth_after_cam = teeth_after_cam + 16'd1;
      end
      last_ticks = t;
      if (pos > TEETH - 1) begin
        pos = '0;
        speed_lvl = zone_from_ticks(t);
      end else if (pos == 13 || pos == 14 || pos == 16 || pos == 17 ||
                   pos == 31 || pos == 32) begin
        pos = pos + 7'd1;
      end else if (pos == 12 || pos == 30) begin
        deg = {8'd0, cfg_window_deg} - {10'd0, advance_map[{speed_lvl, load_lvl}]};
        product = deg;
        product = product * t;
        product = (product / 10) * 128;
        r.arm = 1'b1;
        r.spark_compare = product[15:0];
        r.dwell_end = product[15:0] + cfg_dwell;
      end
      tooth_cnt = pos[5:0];
      if (tooth_cnt == 1 && cam_ph == 2) plug_sel = 4'b0001;
      else if (tooth_cnt == 1 && cam_ph == 0) plug_sel = 4'b0010;
      else if (tooth_cnt == 19 && cam_ph == 2) plug_sel = 4'b0100;
      else if (tooth_cnt == 19 && cam_ph == 1) plug_sel = 4'b1000;
      else if (tooth_cnt == 15 && cam_ph == 2) inj_sel = 4'b0001;
      else if (tooth_cnt == 15 && cam_ph == 0) inj_sel = 4'b0010;
      else if (tooth_cnt == 33 && cam_ph == 2) inj_sel = 4'b0100;
      else if (tooth_cnt == 33 && cam_ph == 1) inj_sel = 4'b1000;
    end else if (m == ccis_pkg::MODE_CAM) begin
      cam_ph = cam_ph + 8'd1;
      if (teeth_after_cam > {8'd0, cfg_cam_gap}) cam_ph = '0;
      teeth_after_cam = '0;
    end else if (m == ccis_pkg::MODE_THROTTLE) begin
      load_lvl = thr[7:5];
      duty_val = ({5'd0, speed_lvl} + 8'd1) * 8'd10;
    end
    r.tooth = tooth_cnt;
    r.speed = speed_lvl;
    r.load = load_lvl;
    r.plug = plug_sel;
    r.inj = inj_sel;
    r.duty = duty_val;
    r.window = (tooth_cnt > 12 && tooth_cnt < 19) || tooth_cnt >= 30 || tooth_cnt == 0;
    return r;
  endfunction

  task automatic check_result();
    ccis_pkg::out_t got;
    ccis_pkg::out_t want;
    got.tooth = tooth_position;
    got.speed = speed_zone;
    got.load = load_level;
    got.arm = spark_arm;
    got.spark_compare = spark_compare;
    got.dwell_end = dwell_end_compare;
    got.plug = plug_mask;
    got.inj = injector_mask;
    got.duty = injector_duty;
    got.window = spark_window;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result with no transaction pending at %0t", $realtime);
    end else begin
      want = pending_results.pop_front();
      if (got.tooth !== want.tooth || got.speed !== want.speed || got.load !== want.load ||
          got.arm !== want.arm || got.spark_compare !== want.spark_compare ||
          got.dwell_end !== want.dwell_end || got.plug !== want.plug ||
          got.inj !== want.inj || got.duty !== want.duty || got.window !== want.window) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  exp pos=%0d spd=%0d ld=%0d arm=%0d cmp=%h dw=%h plug=%b inj=%b duty=%0d w=%0d",
                   want.tooth, want.speed, want.load, want.arm, want.spark_compare,
                   want.dwell_end, want.plug, want.inj, want.duty, want.window);
          $display("  got pos=%0d spd=%0d ld=%0d arm=%0d cmp=%h dw=%h plug=%b inj=%b duty=%0d w=%0d",
                   got.tooth, got.speed, got.load, got.arm, got.spark_compare,
                   got.dwell_end, got.plug, got.inj, got.duty, got.window);
        end
      end
    end
  endtask

  logic [12:0] ready_pattern = '1;
  int ready_age = 0;

  always @(posedge clk) begin
    if (out_valid && out_ready) check_result();
    ready_age = ready_age + 1;
    if (ready_age >= 150) begin
      ready_age = 0;
      ready_pattern = ($urandom_range(0, 3) == 0) ? '1 : (13'($urandom) | 13'd1);
    end
    out_ready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[12:1]};
  end

  task automatic send_item(logic [1:0] m, logic [7:0] ticks, logic [7:0] thr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(1, 9) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= m;
    tooth_ticks <= ticks;
    throttle <= thr;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(decode_item(m, ticks, thr));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ccis_pkg::REG_SPARK_WINDOW: cfg_window_deg = value[7:0];
      ccis_pkg::REG_DWELL_OFFSET: cfg_dwell = value[15:0];
      ccis_pkg::REG_CAM_GAP: cfg_cam_gap = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] window_deg, logic [15:0] dwell, logic [7:0] cam_gap);
    wait_idle();
    write_reg(ccis_pkg::REG_SPARK_WINDOW, {24'd0, window_deg});
    write_reg(ccis_pkg::REG_DWELL_OFFSET, {16'd0, dwell});
    write_reg(ccis_pkg::REG_CAM_GAP, {24'd0, cam_gap});
  endtask

  // mostly steady tooth trains with gap teeth, cam edges and throttle samples;
  // the rest is random noise including the unused mode
  task automatic run_engine(int count);
    int sent;
    int base;
    int run_len;
    int cam_at;
    int v;
    sent = 0;
    cam_at = $urandom_range(4, 24);
    while (sent < count) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 20)) begin
          send_item(2'($urandom), 8'($urandom), 8'($urandom));
          sent++;
        end
      end else begin
        base = ($urandom_range(0, 7) == 0) ? $urandom_range(86, 255) : $urandom_range(1, 85);
        run_len = $urandom_range(20, 80);
        repeat (run_len) begin
          if (teeth_after_cam >= cam_at) begin
            send_item(ccis_pkg::MODE_CAM, 8'($urandom), 8'($urandom));
            sent++;
            cam_at = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 300)
                                                 : $urandom_range(4, 24);
          end
          if ($urandom_range(0, 9) == 0) begin
            send_item(ccis_pkg::MODE_THROTTLE, 8'($urandom), 8'($urandom));
            sent++;
          end
          if ($urandom_range(0, 11) == 0) v = base * 3 + int'($urandom_range(1, 3));
          else v = base + int'($urandom_range(0, 2)) - 1;
          if (v > 255) v = 255;
          send_item(ccis_pkg::MODE_CRANK, 8'(v), 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed();
    send_item(MODE_UNUSED, 8'hFF, 8'hFF);
    send_item(ccis_pkg::MODE_THROTTLE, 8'h00, 8'hFF);
    send_item(ccis_pkg::MODE_THROTTLE, 8'hFF, 8'h00);
    send_item(ccis_pkg::MODE_CRANK, 8'h00, 8'h00);
    send_item(ccis_pkg::MODE_CRANK, 8'hFF, 8'h00);
    send_item(ccis_pkg::MODE_CAM, 8'h00, 8'h00);
    repeat (12) send_item(ccis_pkg::MODE_CRANK, 8'd85, 8'h00);
    send_item(ccis_pkg::MODE_CRANK, 8'hFF, 8'hFF);
    send_item(ccis_pkg::MODE_CAM, 8'hFF, 8'hFF);
    send_item(ccis_pkg::MODE_CAM, 8'h00, 8'h00);
  endtask

  task automatic test_default_config();
    run_engine(500);
  endtask

  task automatic test_low_extremes();
    set_config(8'd0, 16'hFFFF, 8'd0);
    run_engine(300);
  endtask

  task automatic test_high_extremes();
    set_config(8'd255, 16'd0, 8'd255);
    run_engine(300);
  endtask

  task automatic test_random_config();
    repeat (3) begin
      set_config(8'($urandom), 16'($urandom), 8'($urandom_range(4, 40)));
      run_engine(100);
    end
  endtask

  task automatic test_pause_until_drained();
    set_config(ccis_pkg::SPARK_WINDOW_RESET, ccis_pkg::DWELL_OFFSET_RESET,
               ccis_pkg::CAM_GAP_RESET);
    repeat (4) begin
      run_engine(50);
      wait_idle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_default_config();
    test_low_extremes();
    test_high_extremes();
    test_random_config();
    test_pause_until_drained();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ccis_pkg.sv
hdl/ccis_decode.sv
hdl/ccis_compare.sv
hdl/crank_cam_ignition_scheduler.sv
bench/testbench.sv
